// File: src/rsi_trend_signal_macros.svh
// ---------------------------------------------------------------------------
// RSI trend signal assertion macros
// Property check wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RSI_TREND_SIGNAL_MACROS_SVH
`define RSI_TREND_SIGNAL_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property on every rising edge outside reset.
`define RTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define RTS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);
`else
`define RTS_ASSERT(label, clk, rst, prop, msg)
`define RTS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif

`endif

// File: src/rts_pkg.sv
// ---------------------------------------------------------------------------
// RSI trend signal package
// Field widths, register codes, action codes and shared structures.
// ---------------------------------------------------------------------------
package rts_pkg;

   // Payload and register widths.
   localparam int SYMBOL_W   = 16;
   localparam int PRICE_W    = 32;
   localparam int HELD_W     = 32;
   localparam int PERIOD_W   = 8;
   localparam int TREND_W    = 9;
   localparam int LEVEL_W    = 14;
   localparam int QTY_W      = 31;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [SYMBOL_W-1:0] SYMBOL_RESET     = 16'd0;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 8'd14;
   localparam logic [TREND_W-1:0]  TREND_RESET      = 9'd50;
   localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RESET = 14'd7000;
   localparam logic [LEVEL_W-1:0]  OVERSOLD_RESET   = 14'd3000;

   // RSI scale in hundredths, and the value used when nothing moved.
   localparam logic [LEVEL_W-1:0]  RSI_SCALE   = 14'd10000;
   localparam logic [LEVEL_W-1:0]  RSI_NEUTRAL = 14'd5000;

   // Register index, taken from the word address.
   typedef enum logic [2:0] {
      REG_SYMBOL     = 3'd0,
      REG_PERIOD     = 3'd1,
      REG_TREND      = 3'd2,
      REG_OVERBOUGHT = 3'd3,
      REG_OVERSOLD   = 3'd4
   } reg_index_type;

   // Order action codes.
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol_match;
      logic [PERIOD_W-1:0] rsi_period;
      logic [TREND_W-1:0]  trend_length;
      logic [LEVEL_W-1:0]  overbought_level;
      logic [LEVEL_W-1:0]  oversold_level;
      logic                window_clear;
   } cfg_type;

   // Bar handed from the window stage to the decision stage.
   typedef struct packed {
      logic [PRICE_W-1:0] close_price;
      logic [HELD_W-1:0]  held_quantity;
      logic               evaluate;
      logic               window_ready;
   } bar_type;

endpackage

// File: src/rts_req_if.sv
// ---------------------------------------------------------------------------
// RSI trend signal bar channel
// Valid/ready channel that carries one price bar per transfer.
// ---------------------------------------------------------------------------
interface rts_req_if;
   logic                              valid;
   logic                              ready;
   logic [rts_pkg::SYMBOL_W-1:0]      symbol_id;
   logic [rts_pkg::PRICE_W-1:0]       close_price;
   logic signed [rts_pkg::HELD_W-1:0] held_quantity;

   modport source (output valid, symbol_id, close_price, held_quantity, input ready);
   modport sink   (input valid, symbol_id, close_price, held_quantity, output ready);
endinterface

// File: src/rts_rsp_if.sv
// ---------------------------------------------------------------------------
// RSI trend signal order channel
// Valid/ready channel that carries one order decision per transfer.
// ---------------------------------------------------------------------------
interface rts_rsp_if;
   logic                        valid;
   logic                        ready;
   rts_pkg::action_type         action;
   logic [rts_pkg::QTY_W-1:0]   order_quantity;
   logic                        window_ready;

   modport source (output valid, action, order_quantity, window_ready, input ready);
   modport sink   (input valid, action, order_quantity, window_ready, output ready);
endinterface

// File: src/rts_csr.sv
// ---------------------------------------------------------------------------
// RSI trend signal register file
// APB-style configuration registers with read back.
// ---------------------------------------------------------------------------
module rts_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output rts_pkg::cfg_type                 cfg
);
   import rts_pkg::*;

   logic                wr_en;
   reg_index_type       reg_idx;
   logic [SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [TREND_W-1:0]  trend_ff, trend_in;
   logic [LEVEL_W-1:0]  overbought_ff, overbought_in;
   logic [LEVEL_W-1:0]  oversold_ff, oversold_in;

   // The access phase of every transfer completes without wait states.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // Write decode.
   always_comb begin
      symbol_in     = symbol_ff;
      period_in     = period_ff;
      trend_in      = trend_ff;
      overbought_in = overbought_ff;
      oversold_in   = oversold_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SYMBOL:     symbol_in     = csr_pwdata[SYMBOL_W-1:0];
            REG_PERIOD:     period_in     = csr_pwdata[PERIOD_W-1:0];
            REG_TREND:      trend_in      = csr_pwdata[TREND_W-1:0];
            REG_OVERBOUGHT: overbought_in = csr_pwdata[LEVEL_W-1:0];
            REG_OVERSOLD:   oversold_in   = csr_pwdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_ff     <= SYMBOL_RESET;
         period_ff     <= PERIOD_RESET;
         trend_ff      <= TREND_RESET;
         overbought_ff <= OVERBOUGHT_RESET;
         oversold_ff   <= OVERSOLD_RESET;
      end else begin
         symbol_ff     <= symbol_in;
         period_ff     <= period_in;
         trend_ff      <= trend_in;
         overbought_ff <= overbought_in;
         oversold_ff   <= oversold_in;
      end
   end

   // Read back mux.
   always_comb begin
      unique case (reg_idx)
         REG_SYMBOL:     csr_prdata = CSR_DATA_W'(symbol_ff);
         REG_PERIOD:     csr_prdata = CSR_DATA_W'(period_ff);
         REG_TREND:      csr_prdata = CSR_DATA_W'(trend_ff);
         REG_OVERBOUGHT: csr_prdata = CSR_DATA_W'(overbought_ff);
         REG_OVERSOLD:   csr_prdata = CSR_DATA_W'(oversold_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // A new period or trend length restarts the window fill.
   always_comb begin
      cfg.symbol_match     = symbol_ff;
      cfg.rsi_period       = period_ff;
      cfg.trend_length     = trend_ff;
      cfg.overbought_level = overbought_ff;
      cfg.oversold_level   = oversold_ff;
      cfg.window_clear     = wr_en && (reg_idx == REG_PERIOD || reg_idx == REG_TREND);
   end

endmodule

// File: src/rts_window.sv
// ---------------------------------------------------------------------------
// RSI trend signal close window
// Bar input register, close and difference stores, and running sums.
// ---------------------------------------------------------------------------
`include "rsi_trend_signal_macros.svh"

module rts_window #(
   parameter int MAX_WINDOW = 256,
   parameter int ADDR_W     = 8,
   parameter int COUNT_W    = 9,
   parameter int SUM_W      = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   rts_req_if.sink              req,
   input  rts_pkg::cfg_type     cfg,
   input  logic                 bar_ready,
   output logic                 bar_valid,
   output rts_pkg::bar_type     bar,
   output logic [SUM_W-1:0]     gain_total,
   output logic [SUM_W-1:0]     loss_total,
   output logic [SUM_W-1:0]     move_total,
   output logic [SUM_W-1:0]     close_total,
   output logic [COUNT_W-1:0]   trend_eff
);
   import rts_pkg::*;

   localparam int AX_W = ADDR_W + 2;

   // Stores: closes, and each close's move from the one before it.
   logic [PRICE_W-1:0] close_mem [MAX_WINDOW];
   logic [PRICE_W:0]   diff_mem  [MAX_WINDOW];

   // Effective window shape.
   logic [ADDR_W-1:0]  p_eff;
   logic [COUNT_W-1:0] p_next;
   logic [COUNT_W-1:0] w_len;

   // Handshake.
   logic s2_ready, s1_go, accept, match, push;

   // Bar input register.
   logic                s1_valid_ff, s1_valid_in;
   logic [SYMBOL_W-1:0] sym_ff;
   logic [PRICE_W-1:0]  price_ff;
   logic [HELD_W-1:0]   held_ff;

   // Window state.
   logic [ADDR_W-1:0]  ws_ff, ws_in, ws_next, ws_eff;
   logic [COUNT_W-1:0] fill_ff, fill_in, fill_new;
   logic [SUM_W-1:0]   gain_total_ff, gain_total_in;
   logic [SUM_W-1:0]   loss_total_ff, loss_total_in;
   logic [SUM_W-1:0]   move_total_ff, move_total_in;
   logic [SUM_W-1:0]   close_total_ff, close_total_in;
   logic [PRICE_W-1:0] last_close_ff;
   logic [PRICE_W:0]   last_diff_ff;

   // Read side of the stores.
   logic [AX_W-1:0]    rd_diff_sum, rd_close_sum;
   logic [ADDR_W-1:0]  rd_diff_addr, rd_close_addr;
   logic               byp_diff_in, byp_close_in;
   logic               byp_diff_ff, byp_close_ff;
   logic [PRICE_W-1:0] rd_close_ff;
   logic [PRICE_W:0]   rd_diff_ff;

   // Running sum update terms.
   logic               have_prev, gain_up, drop_diff, drop_close;
   logic [PRICE_W-1:0] mag;
   logic [PRICE_W:0]   old_diff;
   logic [PRICE_W-1:0] old_close;
   logic [SUM_W-1:0]   add_g, add_l, sub_g, sub_l;

   // Result stage register.
   logic    bar_valid_ff, bar_valid_in;
   bar_type bar_ff, bar_in;

   // Zero means one, and the period and length are capped by the store depth.
   always_comb begin
      if (cfg.rsi_period == '0) begin
         p_eff = ADDR_W'(1);
      end else if (32'(cfg.rsi_period) > 32'(MAX_WINDOW - 1)) begin
         p_eff = ADDR_W'(MAX_WINDOW - 1);
      end else begin
         p_eff = ADDR_W'(cfg.rsi_period);
      end
      if (cfg.trend_length == '0) begin
         trend_eff = COUNT_W'(1);
      end else if (32'(cfg.trend_length) > 32'(MAX_WINDOW)) begin
         trend_eff = COUNT_W'(MAX_WINDOW);
      end else begin
         trend_eff = COUNT_W'(cfg.trend_length);
      end
      p_next = COUNT_W'(p_eff) + COUNT_W'(1);
      w_len  = (p_next > trend_eff) ? p_next : trend_eff;
   end

   // Stage handshake: each register moves when the next one can take it.
   assign s2_ready  = !bar_valid_ff || bar_ready;
   assign s1_go     = s1_valid_ff && s2_ready;
   assign req.ready = !s1_valid_ff || s2_ready;
   assign accept    = req.valid && req.ready;
   assign match     = (sym_ff == cfg.symbol_match);
   assign push      = s1_go && match;

   // Ring slot after the bar that may push at this edge.
   always_comb begin
      ws_next = (ws_ff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : ws_ff + ADDR_W'(1);
      ws_eff  = push ? ws_next : ws_ff;
   end

   // The accepted bar needs the move leaving the gain window and the close
   // leaving the trend window; both are read at the transfer edge.
   always_comb begin
      rd_diff_sum   = AX_W'(ws_eff) + AX_W'(MAX_WINDOW) - AX_W'(p_eff);
      rd_close_sum  = AX_W'(ws_eff) + AX_W'(MAX_WINDOW) - AX_W'(trend_eff);
      rd_diff_addr  = (rd_diff_sum >= AX_W'(MAX_WINDOW))
                    ? ADDR_W'(rd_diff_sum - AX_W'(MAX_WINDOW)) : ADDR_W'(rd_diff_sum);
      rd_close_addr = (rd_close_sum >= AX_W'(MAX_WINDOW))
                    ? ADDR_W'(rd_close_sum - AX_W'(MAX_WINDOW)) : ADDR_W'(rd_close_sum);
      // A slot written at this same edge is taken from the newest-close registers.
      byp_diff_in   = push && (rd_diff_addr == ws_ff);
      byp_close_in  = push && (rd_close_addr == ws_ff);
   end

   // Store writes and registered reads.
   always_ff @(posedge clock) begin
      if (push) begin
         close_mem[ws_ff] <= price_ff;
         diff_mem[ws_ff]  <= {gain_up, mag};
      end
      if (accept) begin
         rd_close_ff <= close_mem[rd_close_addr];
         rd_diff_ff  <= diff_mem[rd_diff_addr];
      end
   end

   // Move of the new close and the terms leaving both windows.
   always_comb begin
      have_prev  = (fill_ff != '0);
      gain_up    = (price_ff > last_close_ff);
      mag        = gain_up ? (price_ff - last_close_ff) : (last_close_ff - price_ff);
      old_diff   = byp_diff_ff ? last_diff_ff : rd_diff_ff;
      old_close  = byp_close_ff ? last_close_ff : rd_close_ff;
      drop_diff  = (fill_ff > COUNT_W'(p_eff));
      drop_close = (fill_ff >= trend_eff);
      add_g      = (have_prev && gain_up) ? SUM_W'(mag) : '0;
      add_l      = (have_prev && !gain_up) ? SUM_W'(mag) : '0;
      sub_g      = (drop_diff && old_diff[PRICE_W]) ? SUM_W'(old_diff[PRICE_W-1:0]) : '0;
      sub_l      = (drop_diff && !old_diff[PRICE_W]) ? SUM_W'(old_diff[PRICE_W-1:0]) : '0;
      fill_new   = (fill_ff == COUNT_W'(MAX_WINDOW)) ? fill_ff : fill_ff + COUNT_W'(1);
   end

   // Next window state.
   always_comb begin
      ws_in          = ws_ff;
      fill_in        = fill_ff;
      gain_total_in  = gain_total_ff;
      loss_total_in  = loss_total_ff;
      move_total_in  = move_total_ff;
      close_total_in = close_total_ff;
      if (cfg.window_clear) begin
         fill_in        = '0;
         gain_total_in  = '0;
         loss_total_in  = '0;
         move_total_in  = '0;
         close_total_in = '0;
      end else if (push) begin
         ws_in          = ws_next;
         fill_in        = fill_new;
         gain_total_in  = gain_total_ff + add_g - sub_g;
         loss_total_in  = loss_total_ff + add_l - sub_l;
         move_total_in  = move_total_ff + add_g + add_l - sub_g - sub_l;
         close_total_in = close_total_ff + SUM_W'(price_ff)
                        - (drop_close ? SUM_W'(old_close) : '0);
      end
   end

   // Stage valid bits and the bar passed on.
   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_go);
      bar_valid_in = s1_go || (bar_valid_ff && !bar_ready);
      bar_in.close_price   = price_ff;
      bar_in.held_quantity = held_ff;
      bar_in.evaluate      = match && (fill_new >= w_len);
      bar_in.window_ready  = match ? (fill_new >= w_len) : (fill_ff >= w_len);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         bar_valid_ff   <= 1'b0;
         ws_ff          <= '0;
         fill_ff        <= '0;
         gain_total_ff  <= '0;
         loss_total_ff  <= '0;
         move_total_ff  <= '0;
         close_total_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         bar_valid_ff   <= bar_valid_in;
         ws_ff          <= ws_in;
         fill_ff        <= fill_in;
         gain_total_ff  <= gain_total_in;
         loss_total_ff  <= loss_total_in;
         move_total_ff  <= move_total_in;
         close_total_ff <= close_total_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff       <= req.symbol_id;
         price_ff     <= req.close_price;
         held_ff      <= req.held_quantity;
         byp_diff_ff  <= byp_diff_in;
         byp_close_ff <= byp_close_in;
      end
      if (push) begin
         last_close_ff <= price_ff;
         last_diff_ff  <= {gain_up, mag};
      end
      if (s1_go) begin
         bar_ff <= bar_in;
      end
   end

   assign bar_valid   = bar_valid_ff;
   assign bar         = bar_ff;
   assign gain_total  = gain_total_ff;
   assign loss_total  = loss_total_ff;
   assign move_total  = move_total_ff;
   assign close_total = close_total_ff;

   // Checks.
   `RTS_ASSERT(a_move_total, clock, reset, move_total_ff == gain_total_ff + loss_total_ff, "move total differs from gain plus loss")
   `RTS_ASSERT(a_fill_bound, clock, reset, fill_ff <= COUNT_W'(MAX_WINDOW), "fill count beyond store depth")
   `RTS_ASSERT_NEXT(a_stage_move, clock, reset, s1_go, bar_valid_ff, "bar lost between stages")

endmodule

// File: src/rts_decide.sv
// ---------------------------------------------------------------------------
// RSI trend signal decision stage
// RSI and trend comparisons by cross products, and the order register.
// ---------------------------------------------------------------------------
`include "rsi_trend_signal_macros.svh"

module rts_decide #(
   parameter int COUNT_W  = 9,
   parameter int SUM_W    = 40,
   parameter int BUY_SIZE = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rts_pkg::cfg_type     cfg,
   input  logic                 bar_valid,
   input  rts_pkg::bar_type     bar,
   output logic                 bar_ready,
   input  logic [SUM_W-1:0]     gain_total,
   input  logic [SUM_W-1:0]     loss_total,
   input  logic [SUM_W-1:0]     move_total,
   input  logic [SUM_W-1:0]     close_total,
   input  logic [COUNT_W-1:0]   trend_eff,
   rts_rsp_if.source            rsp
);
   import rts_pkg::*;

   localparam int PW = SUM_W + LEVEL_W;

   logic [PW-1:0] gain_scaled, over_limit, under_limit, trend_prod;
   logic          still, rsi_low, rsi_high, above, below, held_zero, held_pos;

   logic             rsp_valid_ff, rsp_valid_in;
   action_type       action_ff, action_in;
   logic [QTY_W-1:0] qty_ff, qty_in;
   logic             ready_ff, ready_in;

   // The order register takes a new bar whenever it empties or is taken.
   assign bar_ready = !rsp_valid_ff || rsp.ready;

   // Cross products: RSI against both levels, price against the average.
   always_comb begin
      gain_scaled = PW'(gain_total) * PW'(RSI_SCALE);
      over_limit  = PW'(move_total) * PW'(cfg.overbought_level);
      under_limit = PW'(move_total) * PW'(cfg.oversold_level);
      trend_prod  = PW'(bar.close_price) * PW'(trend_eff);
      still       = (gain_total + loss_total == '0);
      rsi_low     = still ? (RSI_NEUTRAL < cfg.oversold_level) : (gain_scaled < under_limit);
      rsi_high    = still ? (RSI_NEUTRAL > cfg.overbought_level) : (gain_scaled > over_limit);
      above       = (trend_prod > PW'(close_total));
      below       = (trend_prod < PW'(close_total));
      held_zero   = (bar.held_quantity == '0);
      held_pos    = !bar.held_quantity[HELD_W-1] && !held_zero;
   end

   // Order choice: buy from flat, sell a long position.
   always_comb begin
      action_in = ACT_NONE;
      qty_in    = '0;
      ready_in  = bar.window_ready;
      if (bar.evaluate) begin
         if (held_zero && rsi_low && above) begin
            action_in = ACT_BUY;
            qty_in    = QTY_W'(BUY_SIZE);
         end else if (held_pos && (rsi_high || below)) begin
            action_in = ACT_SELL;
            qty_in    = bar.held_quantity[QTY_W-1:0];
         end
      end
      rsp_valid_in = bar_valid || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bar_valid && bar_ready) begin
         action_ff <= action_in;
         qty_ff    <= qty_in;
         ready_ff  <= ready_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.action         = action_ff;
   assign rsp.order_quantity = qty_ff;
   assign rsp.window_ready   = ready_ff;

   // Checks.
   `RTS_ASSERT(a_idle_qty, clock, reset, rsp_valid_ff && action_ff == ACT_NONE |-> qty_ff == '0, "quantity without an order")
   `RTS_ASSERT(a_order_full, clock, reset, rsp_valid_ff && action_ff != ACT_NONE |-> ready_ff, "order before the window filled")

endmodule

// File: src/rsi_trend_signal.sv
// ---------------------------------------------------------------------------
// RSI trend signal
// RSI mean-reversion orders for one symbol, gated by a moving-average trend.
// ---------------------------------------------------------------------------
// Bars arrive on req (symbol, close, held quantity) and every bar, whether
// its symbol matches or not, yields exactly one transfer on rsp (action,
// order quantity, window-ready flag), in arrival order.
// The block takes one bar per cycle while the receiver keeps up. A result
// is presented once its bar has passed three registers: the bar input
// register, where the close and difference stores are read and the running
// sums updated, the decision stage with its cross products, and the order
// register.
// Each stage moves as soon as the one after it has room, so a stalled
// receiver holds the order register and the stages fill behind it; req.ready
// falls only once all three hold a bar.
// Reset empties the stages, sets the fill count, write slot and sums to zero
// and loads the register defaults; the stores are not cleared and need no
// pass. Writing rsi_period or trend_length restarts the fill. The user must
// write registers via csr_* only while no bar is in flight; it is unchecked.
// ---------------------------------------------------------------------------
module rsi_trend_signal #(
   parameter int MAX_WINDOW = 256,
   parameter int BUY_SIZE   = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   rts_req_if.sink                          req,
   rts_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import rts_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_WINDOW);
   localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W   = PRICE_W + $clog2(MAX_WINDOW);

   cfg_type            cfg;
   logic               bar_valid, bar_ready;
   bar_type            bar;
   logic [SUM_W-1:0]   gain_total, loss_total, move_total, close_total;
   logic [COUNT_W-1:0] trend_eff;

   // Configuration registers.
   rts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Close window and running sums.
   rts_window #(
      .MAX_WINDOW (MAX_WINDOW),
      .ADDR_W     (ADDR_W),
      .COUNT_W    (COUNT_W),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .cfg         (cfg),
      .bar_ready   (bar_ready),
      .bar_valid   (bar_valid),
      .bar         (bar),
      .gain_total  (gain_total),
      .loss_total  (loss_total),
      .move_total  (move_total),
      .close_total (close_total),
      .trend_eff   (trend_eff)
   );

   // Decision and order register.
   rts_decide #(
      .COUNT_W  (COUNT_W),
      .SUM_W    (SUM_W),
      .BUY_SIZE (BUY_SIZE)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .bar_valid   (bar_valid),
      .bar         (bar),
      .bar_ready   (bar_ready),
      .gain_total  (gain_total),
      .loss_total  (loss_total),
      .move_total  (move_total),
      .close_total (close_total),
      .trend_eff   (trend_eff),
      .rsp         (rsp)
   );

endmodule
